// ----- sv/swr_pkg.sv -----
// Package for the sample-without-replacement core: widths, reset values,
// controller state encoding and the command/status structs between modules.
// No dependencies.
package swr_pkg;

	localparam int SIZE_W         = 11;
	localparam int VALUE_W        = 10;
	localparam int WORD_W         = 32;
	localparam int DIV_CNT_W      = $clog2(WORD_W);
	localparam int POOL_DEPTH_DEF = 1024;
	localparam logic [SIZE_W-1:0] POOL_SIZE_RST = SIZE_W'(1024);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_DIV,
		ST_RD_SLOT,
		ST_RD_LAST,
		ST_WRITE,
		ST_DONE
	} swr_state_t;

	typedef struct packed {
		logic fill;
		logic load;
		logic div_step;
		logic rd_slot;
		logic rd_last;
		logic wr;
		logic out_load;
	} swr_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic rem_zero;
		logic div_last;
		logic out_free;
	} swr_sts_t;

endpackage

// ----- sv/swr_ctrl.sv -----
// Controller state machine of the sample-without-replacement core.
// Sequences table refill, modulo reduction and table read-modify-write.
// Depends on swr_pkg.
module swr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             in_valid,
	output logic             in_stall,
	input  swr_pkg::swr_sts_t sts,
	output swr_pkg::swr_cmd_t cmd
);

	swr_pkg::swr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swr_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			swr_pkg::ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = swr_pkg::ST_IDLE;
				end
			end
			swr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					// empty pool: skip straight to the result
					state_d  = sts.rem_zero ? swr_pkg::ST_DONE : swr_pkg::ST_DIV;
				end
			end
			swr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = swr_pkg::ST_RD_SLOT;
				end
			end
			swr_pkg::ST_RD_SLOT: begin
				cmd.rd_slot = 1'b1;
				state_d     = swr_pkg::ST_RD_LAST;
			end
			swr_pkg::ST_RD_LAST: begin
				cmd.rd_last = 1'b1;
				state_d     = swr_pkg::ST_WRITE;
			end
			swr_pkg::ST_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = swr_pkg::ST_DONE;
			end
			swr_pkg::ST_DONE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = swr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swr_pkg::ST_FILL;
			end
		endcase
		// a register write reloads the table from any state
		if (cfg_we) begin
			cmd      = '0;
			in_stall = 1'b1;
			state_d  = swr_pkg::ST_FILL;
		end
	end

endmodule

// ----- sv/swr_dpath.sv -----
// Datapath of the sample-without-replacement core: pool size register,
// draw counter, bit-serial modulo unit, pool table memory and output register.
// Depends on swr_pkg; driven by swr_ctrl.
module swr_dpath #(
	parameter int POOL_DEPTH = swr_pkg::POOL_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [swr_pkg::SIZE_W-1:0]       cfg_wdata,
	input  logic [swr_pkg::WORD_W-1:0]       random_word,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic [swr_pkg::VALUE_W-1:0]      drawn_value,
	output logic                             exhausted,
	output logic [swr_pkg::SIZE_W-1:0]       remaining,
	input  swr_pkg::swr_cmd_t                cmd,
	output swr_pkg::swr_sts_t                sts
);

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int SW = swr_pkg::SIZE_W;

	logic [SW-1:0]                      pool_size_q;
	logic [SW-1:0]                      count_q;
	logic [AW-1:0]                      fill_addr_q;
	logic [swr_pkg::WORD_W-1:0]         word_q;
	logic [SW-1:0]                      rem_q;
	logic [SW-1:0]                      div_rem_q;
	logic [swr_pkg::DIV_CNT_W-1:0]      div_cnt_q;
	logic                               exh_q;
	logic [AW-1:0]                      val_q;
	logic [AW-1:0]                      rd_data_q;
	logic [AW-1:0]                      pool_mem_q [POOL_DEPTH];
	logic                               out_valid_q;
	logic [swr_pkg::VALUE_W-1:0]        drawn_value_q;
	logic                               exhausted_q;
	logic [SW-1:0]                      remaining_q;

	logic [SW-1:0] live_size;
	logic [SW-1:0] rem_c;
	logic [SW:0]   div_try;
	logic [SW-1:0] div_sub;
	logic [SW-1:0] div_next;
	logic [AW-1:0] slot_idx;
	logic [AW-1:0] last_idx;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;

	// saturate the pool size at the table depth
	always_comb begin
		live_size = pool_size_q;
		if (32'(pool_size_q) > 32'(POOL_DEPTH)) begin
			live_size = SW'(POOL_DEPTH);
		end
		rem_c = (count_q < live_size) ? (live_size - count_q) : '0;
	end

	// one restoring step of word mod rem per cycle, MSB first
	always_comb begin
		div_try  = {div_rem_q, word_q[swr_pkg::WORD_W-1]};
		div_sub  = div_try[SW-1:0] - rem_q;
		div_next = (div_try >= {1'b0, rem_q}) ? div_sub : div_try[SW-1:0];
	end

	assign slot_idx = AW'(div_rem_q);
	assign last_idx = AW'(rem_q - SW'(1));

	assign mem_we    = cmd.fill | cmd.wr;
	assign mem_waddr = cmd.fill ? fill_addr_q : slot_idx;
	assign mem_wdata = cmd.fill ? fill_addr_q : rd_data_q;
	assign mem_raddr = cmd.rd_slot ? slot_idx : last_idx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pool_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= pool_mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= swr_pkg::POOL_SIZE_RST;
			count_q     <= '0;
			fill_addr_q <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_size_q <= cfg_wdata;
				count_q     <= '0;
				fill_addr_q <= '0;
			end else begin
				if (cmd.fill) begin
					fill_addr_q <= fill_addr_q + AW'(1);
				end
				if (cmd.wr) begin
					count_q <= count_q + SW'(1);
				end
			end
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + swr_pkg::DIV_CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q    <= random_word;
			rem_q     <= rem_c;
			div_rem_q <= '0;
			exh_q     <= (rem_c == '0);
		end else if (cmd.div_step) begin
			word_q    <= word_q << 1;
			div_rem_q <= div_next;
		end
		if (cmd.rd_last) begin
			val_q <= rd_data_q;
		end
		if (cmd.out_load) begin
			exhausted_q   <= exh_q;
			drawn_value_q <= exh_q ? '0 : swr_pkg::VALUE_W'(val_q);
			remaining_q   <= exh_q ? '0 : rem_q - SW'(1);
		end
	end

	assign sts.fill_last = (fill_addr_q == AW'(POOL_DEPTH - 1));
	assign sts.rem_zero  = (rem_c == '0);
	assign sts.div_last  = (div_cnt_q == swr_pkg::DIV_CNT_W'(swr_pkg::WORD_W - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign drawn_value = drawn_value_q;
	assign exhausted   = exhausted_q;
	assign remaining   = remaining_q;

endmodule

// ----- sv/sample_without_replacement_core.sv -----
// Draws distinct values 0..min(pool_size,POOL_DEPTH)-1 without replacement.
// Input channel (in_valid/in_stall) carries a 32-bit random_word; each transfer
// gives one result transfer on the output channel (out_valid/out_stall) with
// drawn_value, exhausted and remaining.
// The word is reduced modulo the live entry count by a bit-serial unit, one
// bit per cycle; then the table entry at that slot is read, the last live
// entry is read and written into the slot.
// The core takes one draw at a time: in_stall is low only while it is idle,
// so the next word is taken only after the previous result has gone into
// the output register. An exhausted draw skips the modulo loop and the
// table access and goes straight to the output register.
// Reset and every cfg_we write (new pool_size) run a fill pass that loads
// the identity table, all POOL_DEPTH entries; in_stall stays high during it.
// If the receiver stalls, the result holds in the output register while the
// next draw proceeds; that draw waits at its end for the register to free.
// Depends on swr_pkg, swr_ctrl, swr_dpath.
module sample_without_replacement_core #(
	parameter int POOL_DEPTH = swr_pkg::POOL_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swr_pkg::SIZE_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [swr_pkg::WORD_W-1:0]    random_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [swr_pkg::VALUE_W-1:0]   drawn_value,
	output logic                          exhausted,
	output logic [swr_pkg::SIZE_W-1:0]    remaining
);

	swr_pkg::swr_cmd_t cmd;
	swr_pkg::swr_sts_t sts;

	swr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	swr_dpath #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.random_word (random_word),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.drawn_value (drawn_value),
		.exhausted   (exhausted),
		.remaining   (remaining),
		.cmd         (cmd),
		.sts         (sts)
	);

`ifndef SYNTHESIS
	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result loaded over a stalled result");

	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && exhausted) |-> (drawn_value == '0 && remaining == '0))
		else $error("exhausted result carries a value");

	// a pool size write starts a refill, so no input transfer follows
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken right after a pool size write");
`endif

endmodule

// ----- sim/tb_sample_without_replacement_core.sv -----
// Self-checking testbench for sample_without_replacement_core: a directed table, then random
// pool settings and draws, checked against a partial Fisher-Yates draw model kept here.
// Depends on swr_pkg and sample_without_replacement_core.
module tb_sample_without_replacement_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_DEPTH   = swr_pkg::POOL_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1700;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int N_DIR        = 25;

	typedef struct packed {
		logic [swr_pkg::VALUE_W-1:0] value;
		logic                        exh;
		logic [swr_pkg::SIZE_W-1:0]  rem;
	} draw_res_t;

	typedef enum {ROW_CFG, ROW_DRAW} row_kind_t;
	typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY} stall_mode_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] arg;
		bit          typed;
		draw_res_t   res;
	} dir_row_t;

	// Typed results only where the table state is obvious; the rest use the draw model.
	dir_row_t dir_rows [N_DIR] = '{
		'{ROW_DRAW, 32'h0000_0000, 1'b1, '{10'd0, 1'b0, 11'd1023}},
		'{ROW_DRAW, 32'hFFFF_FFFF, 1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h1234_5678, 1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_CFG,  32'd1,         1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'hFFFF_FFFF, 1'b1, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h0000_0000, 1'b1, '{10'd0, 1'b1, 11'd0}},
		'{ROW_CFG,  32'd0,         1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h0000_0000, 1'b1, '{10'd0, 1'b1, 11'd0}},
		'{ROW_DRAW, 32'hFFFF_FFFF, 1'b1, '{10'd0, 1'b1, 11'd0}},
		'{ROW_CFG,  32'd2047,      1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'hFFFF_FFFF, 1'b1, '{10'd1023, 1'b0, 11'd1023}},
		'{ROW_DRAW, 32'h8000_0000, 1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_CFG,  32'd1025,      1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h0000_0000, 1'b1, '{10'd0, 1'b0, 11'd1023}},
		'{ROW_CFG,  32'd2,         1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h0000_0001, 1'b1, '{10'd1, 1'b0, 11'd1}},
		'{ROW_DRAW, 32'h8000_0000, 1'b1, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h0000_0007, 1'b1, '{10'd0, 1'b1, 11'd0}},
		'{ROW_CFG,  32'd1024,      1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h0000_03FF, 1'b1, '{10'd1023, 1'b0, 11'd1023}},
		'{ROW_DRAW, 32'hAAAA_AAAA, 1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h5555_5555, 1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_CFG,  32'd3,         1'b0, '{10'd0, 1'b0, 11'd0}},
		'{ROW_DRAW, 32'h0000_0002, 1'b1, '{10'd2, 1'b0, 11'd2}},
		'{ROW_DRAW, 32'h0000_0002, 1'b1, '{10'd0, 1'b0, 11'd1}}
	};

	logic                        clk;
	logic                        arst_n      = 1'b0;
	logic                        cfg_we      = 1'b0;
	logic [swr_pkg::SIZE_W-1:0]  cfg_wdata   = '0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic [swr_pkg::WORD_W-1:0]  random_word = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic [swr_pkg::VALUE_W-1:0] drawn_value;
	logic                        exhausted;
	logic [swr_pkg::SIZE_W-1:0]  remaining;

	// draw model state
	logic [swr_pkg::VALUE_W-1:0] pool_tbl [POOL_DEPTH];
	logic [swr_pkg::SIZE_W-1:0]  pool_sz;
	logic [swr_pkg::SIZE_W-1:0]  drawn_cnt;

	draw_res_t   expected_draws [$];
	int          fail_cnt   = 0;
	int          n_sent     = 0;
	int          n_results  = 0;
	int          n_exh      = 0;
	int          n_settings = 0;
	int          burst_left = 0;
	bit          idle_on    = 1'b1;
	int unsigned cycle_cnt  = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	sample_without_replacement_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.random_word (random_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drawn_value (drawn_value),
		.exhausted   (exhausted),
		.remaining   (remaining)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d draws still owed", cycle_cnt,
			expected_draws.size());
		$display("status: fail");
		$finish;
	end

	function automatic void reload_pool();
		for (int i = 0; i < POOL_DEPTH; i++) begin
			pool_tbl[i] = swr_pkg::VALUE_W'(i);
		end
		drawn_cnt = '0;
	endfunction

	function automatic draw_res_t predict_draw(input logic [swr_pkg::WORD_W-1:0] word);
		draw_res_t                  r;
		logic [swr_pkg::SIZE_W-1:0] live;
		logic [swr_pkg::SIZE_W-1:0] left;
		logic [swr_pkg::WORD_W-1:0] slot;
		live = (32'(pool_sz) > 32'(POOL_DEPTH)) ? swr_pkg::SIZE_W'(POOL_DEPTH) : pool_sz;
		left = (drawn_cnt < live) ? live - drawn_cnt : '0;
		if (left == '0) begin
			r = '{value: '0, exh: 1'b1, rem: '0};
		end else begin
			slot = word % swr_pkg::WORD_W'(left);
			r.value = pool_tbl[slot];
			r.exh = 1'b0;
			r.rem = left - swr_pkg::SIZE_W'(1);
			// move the last live entry into the vacated slot
			pool_tbl[slot] = pool_tbl[left - swr_pkg::SIZE_W'(1)];
			drawn_cnt = drawn_cnt + swr_pkg::SIZE_W'(1);
		end
		return r;
	endfunction

	task automatic set_pool_size(input logic [swr_pkg::SIZE_W-1:0] sz);
		in_valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_sz = sz;
		reload_pool();
		n_settings++;
	endtask

	task automatic issue_draw(input logic [swr_pkg::WORD_W-1:0] word, input bit typed,
		input draw_res_t typed_res);
		draw_res_t r;
		int gap;
		if (idle_on && burst_left == 0) begin
			gap = int'($urandom_range(1, 6));
			burst_left = int'($urandom_range(1, 16));
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) burst_left--;
		in_valid    <= 1'b1;
		random_word <= word;
		// hold until the transfer
		do @(posedge clk); while (in_stall);
		r = predict_draw(word);
		expected_draws.insert(expected_draws.size(), typed ? typed_res : r);
		n_sent++;
	endtask

	// receiver: stall pattern (none, coin toss, heavy) is redrawn when its random hold runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_left = int'($urandom_range(50, 400));
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		draw_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (exhausted) n_exh++;
			if (expected_draws.size() == 0) begin
				$error("result with no draw pending: drawn_value %0d exhausted %0d remaining %0d",
					drawn_value, exhausted, remaining);
				fail_cnt++;
			end else begin
				want = expected_draws.pop_front();
				if (drawn_value !== want.value) begin
					$error("drawn_value expected %0d actual %0d", want.value, drawn_value);
					fail_cnt++;
				end
				if (exhausted !== want.exh) begin
					$error("exhausted expected %0d actual %0d", want.exh, exhausted);
					fail_cnt++;
				end
				if (remaining !== want.rem) begin
					$error("remaining expected %0d actual %0d", want.rem, remaining);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		logic [swr_pkg::SIZE_W-1:0] sz;
		logic [swr_pkg::WORD_W-1:0] word;
		int n_draw;
		int sel;
		pool_sz = swr_pkg::POOL_SIZE_RST;
		reload_pool();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < N_DIR; k++) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				set_pool_size(dir_rows[k].arg[swr_pkg::SIZE_W-1:0]);
			end else begin
				issue_draw(dir_rows[k].arg, dir_rows[k].typed, dir_rows[k].res);
			end
		end

		// random phases: mostly small pools drawn to exhaustion or past it
		while (n_sent < N_DIR + RANDOM_ITEMS) begin
			sel = int'($urandom_range(0, 19));
			if (sel < 13) begin
				sz = swr_pkg::SIZE_W'($urandom_range(1, 40));
				n_draw = int'(sz) + int'($urandom_range(0, 3));
			end else if (sel < 16) begin
				sz = swr_pkg::SIZE_W'($urandom_range(41, 400));
				n_draw = ($urandom_range(0, 3) == 0) ? int'(sz) + 1
					: int'($urandom_range(10, 60));
			end else if (sel < 17) begin
				sz = '0;
				n_draw = int'($urandom_range(1, 3));
			end else begin
				sz = swr_pkg::SIZE_W'($urandom_range(1000, 2047));
				n_draw = int'($urandom_range(10, 60));
			end
			idle_on = ($urandom_range(0, 3) != 0);
			set_pool_size(sz);
			for (int d = 0; d < n_draw; d++) begin
				case ($urandom_range(0, 7))
					0: word = '0;
					1: word = '1;
					2: word = $urandom_range(0, 2047);
					default: word = $urandom;
				endcase
				issue_draw(word, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("draws checked: %0d of %0d issued, %0d of them on an empty pool",
			n_results, n_sent, n_exh);
		$display("pool settings applied: %0d, cycles run: %0d", n_settings, cycle_cnt);
		if (fail_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
